// ===== rtl/lssc_pkg.sv =====
// Package for the light-seeking stepper controller.
// Holds the sample width, mode codes, register indexes, state and result types
// and the coil pattern table. Depends on nothing.
package lssc_pkg;

   localparam int SENSOR_BITS = 12;
   localparam int SUM_BITS    = SENSOR_BITS + 1;
   localparam int DEAD_BITS   = 12;
   localparam int MAG_BITS    = (SENSOR_BITS > DEAD_BITS) ? SENSOR_BITS : DEAD_BITS;
   localparam int COUNT_BITS  = 6;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 12;

   localparam logic [DEAD_BITS-1:0]  DEADBAND_RESET   = DEAD_BITS'(150);
   localparam logic [COUNT_BITS-1:0] SCAN_STEPS_RESET = COUNT_BITS'(20);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEADBAND   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCAN_STEPS = 1'b1;

   localparam logic DIR_CW  = 1'b0;
   localparam logic DIR_CCW = 1'b1;

   typedef enum logic [1:0] {
      MODE_STARTUP = 2'd0,
      MODE_SCAN    = 2'd1,
      MODE_RETURN  = 2'd2,
      MODE_TRACK   = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type                mode;
      logic [1:0]              phase;
      logic [COUNT_BITS-1:0]   tick_count;
      logic [SUM_BITS-1:0]     best_sum;
      logic [COUNT_BITS-1:0]   best_index;
      logic [3:0]              last_drive;
   } state_type;

   typedef struct packed {
      logic [3:0] coil_drive;
      logic       stepped;
      logic       step_dir;
      logic [1:0] mode_now;
   } result_type;

   // Bit 3 of each pattern drives coil 0.
   function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
      logic [3:0] pat;
      case (phase)
         2'd0:    pat = 4'b0110;
         2'd1:    pat = 4'b1100;
         2'd2:    pat = 4'b1001;
         2'd3:    pat = 4'b0011;
         default: pat = 4'b0110;
      endcase
      return pat;
   endfunction

endpackage

// ===== rtl/lssc_req_if.sv =====
// Input channel of the light-seeking stepper controller: one pair of sensor samples.
// Depends on lssc_pkg for the sample width.
interface lssc_req_if import lssc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SENSOR_BITS-1:0] sensor_a;
   logic [SENSOR_BITS-1:0] sensor_b;

   modport source (output valid, output sensor_a, output sensor_b, input ready);
   modport sink   (input valid, input sensor_a, input sensor_b, output ready);
endinterface

// Result channel of the light-seeking stepper controller: one drive word per tick.
// Depends on nothing beyond plain logic types.
interface lssc_rsp_if ();
   logic       valid;
   logic       ready;
   logic [3:0] coil_drive;
   logic       stepped;
   logic       step_dir;
   logic [1:0] mode_now;

   modport source (output valid, output coil_drive, output stepped, output step_dir,
                   output mode_now, input ready);
   modport sink   (input valid, input coil_drive, input stepped, input step_dir,
                   input mode_now, output ready);
endinterface

// ===== rtl/lssc_step_logic.sv =====
// Next-state and result logic for one tick of the light-seeking stepper controller.
// Purely combinational; depends on lssc_pkg.
module lssc_step_logic import lssc_pkg::*; (
   input  state_type              state_now,
   input  logic [SENSOR_BITS-1:0] sensor_a,
   input  logic [SENSOR_BITS-1:0] sensor_b,
   input  logic [DEAD_BITS-1:0]   deadband,
   input  logic [COUNT_BITS-1:0]  scan_steps,
   output state_type              state_next,
   output result_type             result
);

   logic [COUNT_BITS-1:0]  eff_steps;
   logic [COUNT_BITS-1:0]  tick_inc;
   logic [COUNT_BITS:0]    scan_done_sum;
   logic [COUNT_BITS:0]    ret_done_sum;
   logic [SUM_BITS-1:0]    sample_sum;
   logic [SENSOR_BITS-1:0] diff_mag;
   logic                   track_step;
   logic                   do_step;
   logic                   dir;

   always_comb begin
      eff_steps     = (scan_steps == '0) ? COUNT_BITS'(1) : scan_steps;
      tick_inc      = state_now.tick_count + COUNT_BITS'(1);
      scan_done_sum = {1'b0, state_now.tick_count} + (COUNT_BITS+1)'(1);
      ret_done_sum  = {1'b0, tick_inc} + {1'b0, state_now.best_index};
      sample_sum    = {1'b0, sensor_a} + {1'b0, sensor_b};
      diff_mag      = (sensor_a > sensor_b) ? (sensor_a - sensor_b) : (sensor_b - sensor_a);
      track_step    = (sensor_a != sensor_b) &&
                      (MAG_BITS'(diff_mag) >= MAG_BITS'(deadband));

      state_next = state_now;
      do_step    = 1'b0;
      dir        = DIR_CW;

      case (state_now.mode)
         MODE_STARTUP: begin
            do_step               = 1'b1;
            state_next.tick_count = tick_inc;
            if (tick_inc >= COUNT_BITS'(2)) begin
               state_next.mode       = MODE_SCAN;
               state_next.tick_count = '0;
               state_next.best_sum   = '1;
               state_next.best_index = '0;
            end
         end
         MODE_SCAN: begin
            do_step = 1'b1;
            if (sample_sum < state_now.best_sum) begin
               state_next.best_sum   = sample_sum;
               state_next.best_index = state_now.tick_count;
            end
            if (scan_done_sum >= {1'b0, eff_steps}) begin
               state_next.mode       = MODE_RETURN;
               state_next.tick_count = '0;
            end else begin
               state_next.tick_count = tick_inc;
            end
         end
         MODE_RETURN: begin
            do_step               = 1'b1;
            dir                   = DIR_CCW;
            state_next.tick_count = tick_inc;
            if ((ret_done_sum >= {1'b0, eff_steps}) || (tick_inc == '0)) begin
               state_next.mode       = MODE_TRACK;
               state_next.tick_count = '0;
            end
         end
         MODE_TRACK: begin
            if (track_step) begin
               do_step = 1'b1;
               dir     = (sensor_a > sensor_b) ? DIR_CW : DIR_CCW;
            end
         end
         default: begin
            state_next = state_now;
         end
      endcase

      result.coil_drive = state_now.last_drive;
      result.stepped    = do_step;
      result.step_dir   = dir;
      result.mode_now   = state_now.mode;

      if (do_step) begin
         if (dir == DIR_CW) begin
            result.coil_drive = coil_pattern(state_now.phase);
            state_next.phase  = state_now.phase + 2'd1;
         end else begin
            result.coil_drive = coil_pattern(state_now.phase + 2'd2);
            state_next.phase  = state_now.phase - 2'd1;
         end
         state_next.last_drive = result.coil_drive;
      end
   end

endmodule

// ===== rtl/light_seeking_stepper_controller.sv =====
// Top level of the light-seeking stepper controller: control registers, state
// register and result register. Depends on lssc_pkg, lssc_req_if, lssc_rsp_if
// and lssc_step_logic.
//
//   Channel    Direction  Contents
//   req_chan   in         sensor_a, sensor_b
//   rsp_chan   out        coil_drive, stepped, step_dir, mode_now
//   csr_*      in         deadband (index 0), scan_steps (index 1)
//
// Each transaction yields one result transaction in the following cycle; a new
// transaction is taken every cycle unless a result waits unaccepted, the rate
// being set by the single state update in the step logic. The result register
// frees as soon as its content is taken, so input is only held off while a result waits unaccepted.
// Reset restores the register defaults and the startup mode.
module light_seeking_stepper_controller import lssc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   lssc_req_if.sink                  req_chan,
   lssc_rsp_if.source                rsp_chan,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [DEAD_BITS-1:0]  deadband_ff;
   logic [COUNT_BITS-1:0] scan_steps_ff;
   state_type             state_ff;
   state_type             state_in;
   result_type            result_ff;
   result_type            result_in;
   logic                  rsp_valid_ff;
   logic                  accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   lssc_step_logic u_step (
      .state_now  (state_ff),
      .sensor_a   (req_chan.sensor_a),
      .sensor_b   (req_chan.sensor_b),
      .deadband   (deadband_ff),
      .scan_steps (scan_steps_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff   <= DEADBAND_RESET;
         scan_steps_ff <= SCAN_STEPS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEADBAND:   deadband_ff   <= csr_wdata[DEAD_BITS-1:0];
            CSR_SCAN_STEPS: scan_steps_ff <= csr_wdata[COUNT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode       <= MODE_STARTUP;
         state_ff.phase      <= '0;
         state_ff.tick_count <= '0;
         state_ff.best_sum   <= '1;
         state_ff.best_index <= '0;
         state_ff.last_drive <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.coil_drive = result_ff.coil_drive;
   assign rsp_chan.stepped    = result_ff.stepped;
   assign rsp_chan.step_dir   = result_ff.step_dir;
   assign rsp_chan.mode_now   = result_ff.mode_now;

endmodule

// ===== tb/sv/tb_light_seeking_stepper_controller.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the light-seeking stepper controller: drives sensor pairs,
// predicts each drive word and compares it with the result channel.
// Depends on lssc_pkg, lssc_req_if, lssc_rsp_if and light_seeking_stepper_controller.
module tb_light_seeking_stepper_controller;
   import lssc_pkg::*;

   localparam int SAMPLE_MAX  = 2**SENSOR_BITS - 1;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_AT     = 600;
   localparam int HOLD_CYCLES = 300;
   localparam logic [3:0] COIL_STEPS [4] = '{4'b0110, 4'b1100, 4'b1001, 4'b0011};

   typedef struct packed {
      logic [SENSOR_BITS-1:0] light_a;
      logic [SENSOR_BITS-1:0] light_b;
   } sample_type;

   logic clock;
   logic reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   lssc_req_if req_chan ();
   lssc_rsp_if rsp_chan ();

   light_seeking_stepper_controller u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sample_type sample_backlog[$];
   result_type drive_words_due[$];
   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   int unsigned mismatch_count;
   int unsigned words_checked;

   mode_type              st_mode;
   logic [1:0]            st_phase;
   logic [COUNT_BITS-1:0] st_ticks;
   logic [SUM_BITS-1:0]   st_best_sum;
   logic [COUNT_BITS-1:0] st_best_index;
   logic [3:0]            st_last_drive;
   logic [DEAD_BITS-1:0]  cfg_deadband;
   logic [COUNT_BITS-1:0] cfg_scan_steps;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [3:0] advance_coils(input logic dir);
      logic [3:0] pat;
      if (dir == DIR_CW) begin
         pat = COIL_STEPS[st_phase];
         st_phase = st_phase + 2'd1;
      end else begin
         pat = COIL_STEPS[st_phase + 2'd2];
         st_phase = st_phase - 2'd1;
      end
      st_last_drive = pat;
      return pat;
   endfunction

   function automatic result_type next_drive_word(input logic [SENSOR_BITS-1:0] a,
                                                  input logic [SENSOR_BITS-1:0] b);
      result_type            word;
      logic [COUNT_BITS-1:0] span;
      logic [COUNT_BITS:0]   reach;
      logic [SUM_BITS-1:0]   total;
      logic [SENSOR_BITS-1:0] gap;
      span = (cfg_scan_steps == '0) ? COUNT_BITS'(1) : cfg_scan_steps;
      word.coil_drive = st_last_drive;
      word.stepped    = 1'b0;
      word.step_dir   = DIR_CW;
      word.mode_now   = st_mode;
      case (st_mode)
         MODE_STARTUP: begin
            word.coil_drive = advance_coils(DIR_CW);
            word.stepped = 1'b1;
            st_ticks = st_ticks + 1'b1;
            if (st_ticks >= 2) begin
               st_mode = MODE_SCAN;
               st_ticks = '0;
               st_best_sum = '1;
               st_best_index = '0;
            end
         end
         MODE_SCAN: begin
            total = {1'b0, a} + {1'b0, b};
            if (total < st_best_sum) begin
               st_best_sum = total;
               st_best_index = st_ticks;
            end
            word.coil_drive = advance_coils(DIR_CW);
            word.stepped = 1'b1;
            if ({1'b0, st_ticks} + 1'b1 >= {1'b0, span}) begin
               st_mode = MODE_RETURN;
               st_ticks = '0;
            end else begin
               st_ticks = st_ticks + 1'b1;
            end
         end
         MODE_RETURN: begin
            word.coil_drive = advance_coils(DIR_CCW);
            word.stepped = 1'b1;
            word.step_dir = DIR_CCW;
            st_ticks = st_ticks + 1'b1;
            reach = {1'b0, st_ticks} + {1'b0, st_best_index};
            if (reach >= {1'b0, span} || st_ticks == '0) begin
               st_mode = MODE_TRACK;
               st_ticks = '0;
            end
         end
         default: begin
            gap = (a >= b) ? a - b : b - a;
            if (gap >= cfg_deadband && a != b) begin
               word.step_dir = (a > b) ? DIR_CW : DIR_CCW;
               word.coil_drive = advance_coils(word.step_dir);
               word.stepped = 1'b1;
            end
         end
      endcase
      return word;
   endfunction

   function automatic sample_type random_track_pair();
      sample_type  pair;
      int unsigned pick;
      int unsigned span_gap;
      int unsigned low;
      pick = $urandom_range(9);
      pair.light_a = SENSOR_BITS'($urandom_range(SAMPLE_MAX));
      pair.light_b = SENSOR_BITS'($urandom_range(SAMPLE_MAX));
      if (pick == 0) begin
         pair.light_b = pair.light_a;
      end else if (pick <= 5) begin
         span_gap = cfg_deadband + $urandom_range(2);
         span_gap = (span_gap == 0) ? 0 : span_gap - 1;
         if (span_gap > SAMPLE_MAX) span_gap = SAMPLE_MAX;
         low = $urandom_range(SAMPLE_MAX - span_gap);
         if ($urandom_range(1) == 1) begin
            pair.light_a = SENSOR_BITS'(low + span_gap);
            pair.light_b = SENSOR_BITS'(low);
         end else begin
            pair.light_a = SENSOR_BITS'(low);
            pair.light_b = SENSOR_BITS'(low + span_gap);
         end
      end
      return pair;
   endfunction

   task automatic queue_pair(input int unsigned a, input int unsigned b);
      sample_type pair;
      pair.light_a = SENSOR_BITS'(a);
      pair.light_b = SENSOR_BITS'(b);
      sample_backlog.push_back(pair);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_DEADBAND) cfg_deadband = value[DEAD_BITS-1:0];
      else cfg_scan_steps = value[COUNT_BITS-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (sample_backlog.size() != 0 || drive_words_due.size() != 0 || req_chan.valid);
      repeat (2) @(negedge clock);
   endtask

   task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                   input int unsigned deadband, input int unsigned steps,
                                   input int unsigned count);
      wait_idle();
      write_register(CSR_DEADBAND, CSR_DATA_BITS'(deadband));
      write_register(CSR_SCAN_STEPS,
                     CSR_DATA_BITS'(steps | ($urandom_range(63) << COUNT_BITS)));
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      repeat (count) sample_backlog.push_back(random_track_pair());
   endtask

   always @(posedge clock) begin : drive_samples
      sample_type pair;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            drive_words_due.push_back(next_drive_word(req_chan.sensor_a, req_chan.sensor_b));
         if (!req_chan.valid || req_chan.ready) begin
            if (sample_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               pair = sample_backlog.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.sensor_a <= pair.light_a;
               req_chan.sensor_b <= pair.light_b;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : drive_ready
      int unsigned words_taken;
      int unsigned hold_left;
      bit          hold_done;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         words_taken = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) words_taken++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!hold_done && words_taken == HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_words
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         words_checked++;
         if (drive_words_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Result %0d arrived with no transaction outstanding", words_checked);
         end else begin
            want = drive_words_due.pop_front();
            if (rsp_chan.coil_drive != want.coil_drive || rsp_chan.stepped != want.stepped ||
                rsp_chan.step_dir != want.step_dir || rsp_chan.mode_now != want.mode_now) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"Result %0d: expected drive %b stepped %b dir %b mode %0d, ",
                            "got %b %b %b %0d"},
                           words_checked, want.coil_drive, want.stepped, want.step_dir,
                           want.mode_now, rsp_chan.coil_drive, rsp_chan.stepped,
                           rsp_chan.step_dir, rsp_chan.mode_now);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int unsigned quiet_cycles;
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : run_test
      req_chan.valid    = 1'b0;
      req_chan.sensor_a = '0;
      req_chan.sensor_b = '0;
      rsp_chan.ready    = 1'b0;
      csr_we    = 1'b0;
      csr_index = CSR_DEADBAND;
      csr_wdata = '0;
      reset = 1'b1;
      mismatch_count = 0;
      words_checked = 0;
      sender_idle_pct = 33;
      receiver_idle_pct = 46;
      st_mode = MODE_STARTUP;
      st_phase = '0;
      st_ticks = '0;
      st_best_sum = '1;
      st_best_index = '0;
      st_last_drive = '0;
      cfg_deadband = DEADBAND_RESET;
      cfg_scan_steps = SCAN_STEPS_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Startup ignores the samples; the scan then looks for the first strict minimum.
      write_register(CSR_SCAN_STEPS, CSR_DATA_BITS'(40));
      queue_pair(SAMPLE_MAX, SAMPLE_MAX);
      queue_pair(0, 0);
      queue_pair(SAMPLE_MAX, SAMPLE_MAX);
      queue_pair(100, 200);
      queue_pair(200, 100);
      queue_pair(0, SAMPLE_MAX);
      queue_pair(2048, 2047);
      queue_pair(10, 5);
      queue_pair(5, 10);
      queue_pair(3000, 3000);

      // The scan length is lowered part way through, so the scan stops at the new length.
      wait_idle();
      write_register(CSR_SCAN_STEPS, CSR_DATA_BITS'(12));
      queue_pair(0, 1);
      queue_pair(0, 0);
      queue_pair(0, 0);
      queue_pair(SAMPLE_MAX, 0);
      queue_pair(1234, 567);

      // A zero scan length during the return falls below the best index and ends it.
      wait_idle();
      write_register(CSR_SCAN_STEPS, CSR_DATA_BITS'(0));
      queue_pair(700, 700);
      queue_pair(1000, 1000);
      queue_pair(1149, 1000);
      queue_pair(1150, 1000);
      queue_pair(1000, 1150);
      queue_pair(SAMPLE_MAX, 0);
      queue_pair(0, SAMPLE_MAX);

      wait_idle();
      write_register(CSR_DEADBAND, CSR_DATA_BITS'(0));
      queue_pair(5, 5);
      queue_pair(6, 5);
      queue_pair(2048, 2049);

      wait_idle();
      write_register(CSR_DEADBAND, CSR_DATA_BITS'(4095));
      queue_pair(SAMPLE_MAX, 0);
      queue_pair(SAMPLE_MAX - 1, 0);
      queue_pair(0, SAMPLE_MAX);

      run_random_phase(33, 46, $urandom_range(1, 4094), 63, 440);
      run_random_phase(46, 33, 1, 1, 440);
      run_random_phase(0, 0, $urandom_range(0, 300), $urandom_range(1, 62), 440);

      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && drive_words_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
